/* rtl/arsel_pkg.sv */
`default_nettype none
package arsel_pkg;

  // Fixed field widths
  localparam int WEIGHT_W = 16;
  localparam int MASK_W   = 16;
  localparam int INDEX_W  = 4;
  localparam int MIU_W    = 5;

  // Sum of up to sixteen Q8.8 weights, and the target fraction * sum
  localparam int SUM_W    = WEIGHT_W + 4;
  localparam int TGT_W    = SUM_W + 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;

  // Operation carried by an input beat
  typedef enum logic {
    OP_SELECT = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  // Register index within the APB window (word address)
  typedef enum logic [2:0] {
    REG_DECAY       = 3'd0,
    REG_SCORE_ACC   = 3'd1,
    REG_SCORE_IMP   = 3'd2,
    REG_SCORE_GBEST = 3'd3,
    REG_METHODS     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]      decay_factor;
    logic [15:0]      score_accepted;
    logic [15:0]      score_improved;
    logic [15:0]      score_global_best;
    logic [MIU_W-1:0] methods_in_use;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MUL,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_UPD_RD,
    ST_UPD_M1,
    ST_UPD_M2,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

/* rtl/adaptive_roulette_selector.sv */
`default_nettype none
// Roulette-wheel method selector with adaptive Q8.8 weights held in a small
// single-port-read, single-port-write memory (all weights read as 1.0 after
// reset). One item is worked at a time. A select beat makes one pass over the
// memory to sum the allowed weights (each entry is read and then added, as the
// memory read is registered, and a closing step ends the pass), then forms the
// target, then, if any method is allowed, makes a second pass that stops at the
// first allowed entry whose running sum reaches it, and then loads the output
// register. An update beat is read, put through two multiply steps, of which
// the second writes the new weight back, and then loaded; an update of an
// inactive method goes straight to the load. The load waits while the output
// register still holds an untaken result. The result sits in that register, so
// the next beat is taken while it waits. Configuration is written over the APB
// port at byte addresses 0 to 16; the user must write it only while idle, and
// the block itself does not enforce this.
module adaptive_roulette_selector #(
  parameter int MAX_METHODS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [15:0] random_fraction,
  input  wire logic [15:0] allowed_mask,
  input  wire logic [3:0]  method_index,
  input  wire logic        was_accepted,
  input  wire logic        was_improved,
  input  wire logic        was_global_best,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [3:0]  chosen_index,
  output logic             none_allowed,
  output logic      [15:0] new_weight
);

  localparam int AW = $clog2(MAX_METHODS);

  arsel_pkg::cfg_t cfg;

  logic                           mem_rd_en;
  logic [AW-1:0]                  mem_rd_addr;
  logic [arsel_pkg::WEIGHT_W-1:0] mem_rd_data;
  logic                           mem_wr_en;
  logic [AW-1:0]                  mem_wr_addr;
  logic [arsel_pkg::WEIGHT_W-1:0] mem_wr_data;

  arsel_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arsel_wmem #(
    .DEPTH (MAX_METHODS),
    .AW    (AW)
  ) u_wmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  arsel_engine #(
    .MAX_METHODS (MAX_METHODS),
    .AW          (AW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .random_fraction (random_fraction),
    .allowed_mask    (allowed_mask),
    .method_index    (method_index),
    .was_accepted    (was_accepted),
    .was_improved    (was_improved),
    .was_global_best (was_global_best),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .chosen_index    (chosen_index),
    .none_allowed    (none_allowed),
    .new_weight      (new_weight),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data)
  );

endmodule
`default_nettype wire

/* rtl/arsel_regs.sv */
`default_nettype none
module arsel_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output arsel_pkg::cfg_t        cfg
);

  logic wr_stb;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_stb  = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor      <= 16'd58982;
      cfg.score_accepted    <= 16'd256;
      cfg.score_improved    <= 16'd256;
      cfg.score_global_best <= 16'd256;
      cfg.methods_in_use    <= 5'd16;
    end else if (wr_stb) begin
      case (reg_sel)
        arsel_pkg::REG_DECAY:       cfg.decay_factor      <= pwdata[15:0];
        arsel_pkg::REG_SCORE_ACC:   cfg.score_accepted    <= pwdata[15:0];
        arsel_pkg::REG_SCORE_IMP:   cfg.score_improved    <= pwdata[15:0];
        arsel_pkg::REG_SCORE_GBEST: cfg.score_global_best <= pwdata[15:0];
        arsel_pkg::REG_METHODS:     cfg.methods_in_use    <= pwdata[arsel_pkg::MIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      arsel_pkg::REG_DECAY:       prdata = {16'd0, cfg.decay_factor};
      arsel_pkg::REG_SCORE_ACC:   prdata = {16'd0, cfg.score_accepted};
      arsel_pkg::REG_SCORE_IMP:   prdata = {16'd0, cfg.score_improved};
      arsel_pkg::REG_SCORE_GBEST: prdata = {16'd0, cfg.score_global_best};
      arsel_pkg::REG_METHODS:     prdata = {27'd0, cfg.methods_in_use};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/arsel_wmem.sv */
`default_nettype none
module arsel_wmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rd_en,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic      [arsel_pkg::WEIGHT_W-1:0] rd_data,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [arsel_pkg::WEIGHT_W-1:0] wr_data
);

  logic [arsel_pkg::WEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]               vld;
  logic [arsel_pkg::WEIGHT_W-1:0] data_q;
  logic                           vld_q;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // Track written entries; an unwritten entry reads as 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? data_q : arsel_pkg::WEIGHT_ONE;

endmodule
`default_nettype wire

/* rtl/arsel_engine.sv */
`default_nettype none
module arsel_engine #(
  parameter int MAX_METHODS = 16,
  parameter int AW          = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire arsel_pkg::cfg_t                cfg,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           opcode,
  input  wire logic [15:0]                    random_fraction,
  input  wire logic [arsel_pkg::MASK_W-1:0]   allowed_mask,
  input  wire logic [arsel_pkg::INDEX_W-1:0]  method_index,
  input  wire logic                           was_accepted,
  input  wire logic                           was_improved,
  input  wire logic                           was_global_best,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [arsel_pkg::INDEX_W-1:0]  chosen_index,
  output logic                                none_allowed,
  output logic      [arsel_pkg::WEIGHT_W-1:0] new_weight,
  // weight memory
  output logic                                mem_rd_en,
  output logic      [AW-1:0]                  mem_rd_addr,
  input  wire logic [arsel_pkg::WEIGHT_W-1:0] mem_rd_data,
  output logic                                mem_wr_en,
  output logic      [AW-1:0]                  mem_wr_addr,
  output logic      [arsel_pkg::WEIGHT_W-1:0] mem_wr_data
);

  localparam int ACT_MAX = (MAX_METHODS < arsel_pkg::MASK_W) ? MAX_METHODS
                                                             : arsel_pkg::MASK_W;
  localparam int CW      = $clog2(ACT_MAX + 1);

  arsel_pkg::state_t state, state_next;

  logic [CW-1:0]                  act_n;
  logic [CW-1:0]                  cnt;
  logic                           item_op;
  logic [15:0]                    frac_q;
  logic [arsel_pkg::MASK_W-1:0]   mask_q;
  logic [arsel_pkg::INDEX_W-1:0]  idx_q;
  logic [arsel_pkg::WEIGHT_W-1:0] score_q;
  logic [arsel_pkg::SUM_W-1:0]    sum_q;
  logic [arsel_pkg::SUM_W-1:0]    run_q;
  logic [arsel_pkg::SUM_W-1:0]    run_new;
  logic [arsel_pkg::TGT_W-1:0]    target_q;
  logic                           any_q;
  logic [arsel_pkg::INDEX_W-1:0]  last_q;
  logic [31:0]                    prod_q;
  logic [16:0]                    omd;
  logic [32:0]                    blend;
  logic                           cnt_done;
  logic                           cur_allowed;
  logic                           upd_active;
  logic                           hit;
  logic [arsel_pkg::WEIGHT_W-1:0] score_in;
  logic [arsel_pkg::INDEX_W-1:0]  res_chosen;
  logic                           res_none;
  logic [arsel_pkg::WEIGHT_W-1:0] res_weight;
  logic                           in_beat;
  logic                           out_load;

  // Active methods: methods_in_use saturated to the table and mask widths
  assign act_n = (cfg.methods_in_use > arsel_pkg::MIU_W'(ACT_MAX)) ? CW'(ACT_MAX)
                                                                    : CW'(cfg.methods_in_use);

  assign in_beat     = in_valid & in_ready;
  assign cnt_done    = (cnt == act_n);
  assign cur_allowed = mask_q[arsel_pkg::INDEX_W'(cnt)];
  assign upd_active  = ({1'b0, method_index} < arsel_pkg::MIU_W'(act_n));
  assign run_new     = run_q + arsel_pkg::SUM_W'(mem_rd_data);
  assign hit         = (target_q <= {run_new, 16'd0});
  assign omd         = {1'b1, 16'd0} - {1'b0, cfg.decay_factor};
  assign blend       = {1'b0, prod_q} + (33'(score_q) * 33'(omd));

  // Score: 1.0 raised to the largest configured score of the raised flags
  always_comb begin
    score_in = arsel_pkg::WEIGHT_ONE;
    if (was_accepted && cfg.score_accepted > score_in) begin
      score_in = cfg.score_accepted;
    end
    if (was_improved && cfg.score_improved > score_in) begin
      score_in = cfg.score_improved;
    end
    if (was_global_best && cfg.score_global_best > score_in) begin
      score_in = cfg.score_global_best;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      arsel_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == arsel_pkg::OP_SELECT) state_next = arsel_pkg::ST_SUM_RD;
          else if (upd_active)                state_next = arsel_pkg::ST_UPD_RD;
          else                                state_next = arsel_pkg::ST_FIN;
        end
      end
      arsel_pkg::ST_SUM_RD:  state_next = cnt_done ? arsel_pkg::ST_MUL : arsel_pkg::ST_SUM_ACC;
      arsel_pkg::ST_SUM_ACC: state_next = arsel_pkg::ST_SUM_RD;
      arsel_pkg::ST_MUL:     state_next = any_q ? arsel_pkg::ST_CMP_RD : arsel_pkg::ST_FIN;
      arsel_pkg::ST_CMP_RD:  state_next = cnt_done ? arsel_pkg::ST_FIN : arsel_pkg::ST_CMP_CHK;
      arsel_pkg::ST_CMP_CHK: begin
        state_next = (cur_allowed && hit) ? arsel_pkg::ST_FIN : arsel_pkg::ST_CMP_RD;
      end
      arsel_pkg::ST_UPD_RD:  state_next = arsel_pkg::ST_UPD_M1;
      arsel_pkg::ST_UPD_M1:  state_next = arsel_pkg::ST_UPD_M2;
      arsel_pkg::ST_UPD_M2:  state_next = arsel_pkg::ST_FIN;
      arsel_pkg::ST_FIN:     state_next = (!out_valid || out_ready) ? arsel_pkg::ST_IDLE
                                                                    : arsel_pkg::ST_FIN;
      default:               state_next = arsel_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(cnt);
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(idx_q);
    mem_wr_data = blend[31:16];
    case (state)
      arsel_pkg::ST_IDLE:   in_ready  = 1'b1;
      arsel_pkg::ST_SUM_RD: mem_rd_en = !cnt_done;
      arsel_pkg::ST_CMP_RD: mem_rd_en = !cnt_done;
      arsel_pkg::ST_UPD_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = AW'(idx_q);
      end
      arsel_pkg::ST_UPD_M2: mem_wr_en = 1'b1;
      arsel_pkg::ST_FIN:    out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arsel_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: latch the item, sum pass, target, compare pass, blend
  always_ff @(posedge clk) begin
    case (state)
      arsel_pkg::ST_IDLE: begin
        if (in_beat) begin
          item_op    <= opcode;
          frac_q     <= random_fraction;
          mask_q     <= allowed_mask;
          idx_q      <= method_index;
          score_q    <= score_in;
          cnt        <= '0;
          sum_q      <= '0;
          run_q      <= '0;
          any_q      <= 1'b0;
          last_q     <= '0;
          res_chosen <= '0;
          res_none   <= 1'b0;
          res_weight <= '0;
        end
      end
      arsel_pkg::ST_SUM_ACC: begin
        if (cur_allowed) begin
          sum_q  <= sum_q + arsel_pkg::SUM_W'(mem_rd_data);
          any_q  <= 1'b1;
          last_q <= arsel_pkg::INDEX_W'(cnt);
        end
        cnt <= cnt + 1'b1;
      end
      arsel_pkg::ST_MUL: begin
        target_q <= frac_q * sum_q;
        cnt      <= '0;
        res_none <= !any_q;
      end
      arsel_pkg::ST_CMP_RD: begin
        // fall back to the last allowed method when no entry reaches the target
        if (cnt_done) begin
          res_chosen <= last_q;
        end
      end
      arsel_pkg::ST_CMP_CHK: begin
        if (cur_allowed) begin
          run_q <= run_new;
          if (hit) begin
            res_chosen <= arsel_pkg::INDEX_W'(cnt);
          end
        end
        cnt <= cnt + 1'b1;
      end
      arsel_pkg::ST_UPD_M1: begin
        prod_q <= mem_rd_data * cfg.decay_factor;
      end
      arsel_pkg::ST_UPD_M2: begin
        res_weight <= blend[31:16];
      end
      default: ;
    endcase
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      chosen_index <= (item_op == arsel_pkg::OP_UPDATE) ? '0 : res_chosen;
      none_allowed <= (item_op == arsel_pkg::OP_UPDATE) ? 1'b0 : res_none;
      new_weight   <= (item_op == arsel_pkg::OP_UPDATE) ? res_weight : '0;
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;

  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 7;

  typedef struct packed {
    arsel_pkg::op_t op;
    logic [15:0]    frac;
    logic [15:0]    mask;
    logic [3:0]     idx;
    logic           accepted;
    logic           improved;
    logic           global_best;
  } item_t;

  typedef struct packed {
    logic [3:0]  chosen;
    logic        none;
    logic [15:0] weight;
  } outcome_t;

  // Mirror of the weight table and registers; predicts one outcome per item
  class weight_ledger;
    logic [15:0] weights [16];
    logic [15:0] decay;
    logic [15:0] score_acc;
    logic [15:0] score_imp;
    logic [15:0] score_gbest;
    logic [4:0]  methods;
    outcome_t    pending [$];
    int          errors;
    int          selects;
    int          empties;
    int          updates;
    int          idle_updates;

    function new();
      foreach (weights[i]) weights[i] = arsel_pkg::WEIGHT_ONE;
      decay       = 16'd58982;
      score_acc   = 16'd256;
      score_imp   = 16'd256;
      score_gbest = 16'd256;
      methods     = 5'd16;
      errors = 0;
      selects = 0;
      empties = 0;
      updates = 0;
      idle_updates = 0;
    endfunction

    function int active();
      return (methods > 5'd16) ? 16 : int'(methods);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void set_reg(arsel_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        arsel_pkg::REG_DECAY:       decay = v[15:0];
        arsel_pkg::REG_SCORE_ACC:   score_acc = v[15:0];
        arsel_pkg::REG_SCORE_IMP:   score_imp = v[15:0];
        arsel_pkg::REG_SCORE_GBEST: score_gbest = v[15:0];
        arsel_pkg::REG_METHODS:     methods = v[4:0];
        default: ;
      endcase
    endfunction

    // Work out the outcome of an accepted input beat
    function void note_item(item_t it);
      outcome_t          res;
      int                n;
      int                last;
      bit                found;
      longint unsigned   total;
      longint unsigned   running;
      longint unsigned   target;
      longint unsigned   blend;
      logic [15:0]       score;
      res = '0;
      n = active();
      if (it.op == arsel_pkg::OP_SELECT) begin
        selects++;
        total = 0;
        last = -1;
        for (int i = 0; i < n; i++) begin
          if (it.mask[i]) begin
            total += weights[i];
            last = i;
          end
        end
        if (last < 0) begin
          res.none = 1'b1;
          empties++;
        end else begin
          // exact compare: fraction * total against running sum scaled by 2^16
          target = longint'(it.frac) * total;
          running = 0;
          found = 1'b0;
          for (int i = 0; i < n && !found; i++) begin
            if (it.mask[i]) begin
              running += weights[i];
              if (target <= (running << 16)) begin
                res.chosen = 4'(i);
                found = 1'b1;
              end
            end
          end
          if (!found) res.chosen = 4'(last);
        end
      end else if (int'(it.idx) < n) begin
        updates++;
        score = arsel_pkg::WEIGHT_ONE;
        if (it.accepted && score_acc > score) score = score_acc;
        if (it.improved && score_imp > score) score = score_imp;
        if (it.global_best && score_gbest > score) score = score_gbest;
        blend = (longint'(weights[it.idx]) * decay
                 + longint'(score) * (64'd65536 - decay)) >> 16;
        res.weight = blend[15:0];
        weights[it.idx] = blend[15:0];
      end else begin
        idle_updates++;
      end
      pending = {pending, res};
    endfunction

    // Compare a result beat with the oldest outcome waiting
    function void check_result(logic [3:0] chosen, logic none, logic [15:0] weight);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: chosen %0d none %0b weight %h",
                 $time, chosen, none, weight);
        return;
      end
      want = pending.pop_front();
      if (chosen !== want.chosen) begin
        errors++;
        $display("%0t: chosen_index expected %0d actual %0d", $time, want.chosen, chosen);
      end
      if (none !== want.none) begin
        errors++;
        $display("%0t: none_allowed expected %0b actual %0b", $time, want.none, none);
      end
      if (weight !== want.weight) begin
        errors++;
        $display("%0t: new_weight expected %h actual %h", $time, want.weight, weight);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = 1'b0;
  logic [15:0] random_fraction = '0;
  logic [15:0] allowed_mask = '0;
  logic [3:0]  method_index = '0;
  logic        was_accepted = 1'b0;
  logic        was_improved = 1'b0;
  logic        was_global_best = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  chosen_index;
  logic        none_allowed;
  logic [15:0] new_weight;

  weight_ledger ledger;
  int send_idle = 10;
  int recv_idle = 73;
  int settings_loaded = 0;
  int phase_items [PHASES] = '{100, 60, 100, 20, 110, 110, 100};

  adaptive_roulette_selector uut (.*);

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle);
  end

  // Check each result beat before the edge that takes it
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_result(chosen_index, none_allowed, new_weight);
  end

  function automatic item_t compose_item(arsel_pkg::op_t op, logic [15:0] frac,
                                         logic [15:0] mask, logic [3:0] idx,
                                         logic [2:0] flags);
    item_t it;
    it.op = op;
    it.frac = frac;
    it.mask = mask;
    it.idx = idx;
    it.accepted = flags[0];
    it.improved = flags[1];
    it.global_best = flags[2];
    return it;
  endfunction

  // Random beat, biased toward masks and indexes inside the active range
  function automatic item_t random_item(int active);
    item_t it;
    it.op = $urandom_range(1) ? arsel_pkg::OP_UPDATE : arsel_pkg::OP_SELECT;
    case ($urandom_range(9))
      0: it.frac = 16'h0000;
      1: it.frac = 16'hffff;
      default: it.frac = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0: it.mask = 16'h0000;
      1: it.mask = 16'hffff;
      2: it.mask = 16'd1 << $urandom_range(15);
      3, 4: it.mask = 16'($urandom) & ((active >= 16) ? 16'hffff
                                                       : ((16'd1 << active) - 16'd1));
      default: it.mask = 16'($urandom);
    endcase
    if (active > 0 && $urandom_range(3) != 0)
      it.idx = 4'($urandom_range(active - 1));
    else
      it.idx = 4'($urandom);
    it.accepted = 1'($urandom);
    it.improved = 1'($urandom);
    it.global_best = 1'($urandom);
    return it;
  endfunction

  // Write one register, then read it back; starts and ends on a rising edge
  task automatic write_reg(arsel_pkg::reg_idx_t r, logic [31:0] v);
    logic [31:0] keep;
    keep = (r == arsel_pkg::REG_METHODS) ? 32'h0000_001f : 32'h0000_ffff;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= ($urandom & ~keep) | (v & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    ledger.set_reg(r, v & keep);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== (v & keep)) begin
      ledger.errors++;
      $display("%0t: register %s read expected %h actual %h", $time, r.name(), v & keep, prdata);
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [15:0] decay, logic [15:0] acc, logic [15:0] imp,
                             logic [15:0] gbest, logic [4:0] methods);
    write_reg(arsel_pkg::REG_DECAY, {16'd0, decay});
    write_reg(arsel_pkg::REG_SCORE_ACC, {16'd0, acc});
    write_reg(arsel_pkg::REG_SCORE_IMP, {16'd0, imp});
    write_reg(arsel_pkg::REG_SCORE_GBEST, {16'd0, gbest});
    write_reg(arsel_pkg::REG_METHODS, {27'd0, methods});
    settings_loaded++;
  endtask

  // Hold one beat on the input channel until it is taken
  task automatic push_item(item_t it);
    logic taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    random_fraction <= it.frac;
    allowed_mask <= it.mask;
    method_index <= it.idx;
    was_accepted <= it.accepted;
    was_improved <= it.improved;
    was_global_best <= it.global_best;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    ledger.note_item(it);
  endtask

  // Wait for every pending result, then let the block go quiet
  task automatic settle();
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    ledger = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset weights and registers
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h1234, 16'h0000, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h0000, 16'hffff, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'hffff, 16'hffff, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h8000, 16'h8000, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'hffff, 16'h0001, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h7fff, 16'ha5a5, 4'd0, 3'b000));
    for (int k = 0; k < 8; k++)
      push_item(compose_item(arsel_pkg::OP_UPDATE, 16'($urandom), 16'($urandom),
                             4'(k), 3'(k)));
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'hffff, 4'd15, 3'b111));
    in_valid <= 1'b0;
    settle();

    // Directed: score extremes, three active methods
    load_config(16'd0, 16'hffff, 16'd1000, 16'd0, 5'd3);
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'h0000, 4'd0, 3'b001));
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'h0000, 4'd2, 3'b010));
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'h0000, 4'd1, 3'b100));
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'h0000, 4'd15, 3'b111));
    push_item(compose_item(arsel_pkg::OP_UPDATE, 16'h0000, 16'h0000, 4'd3, 3'b011));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h0001, 16'hffff, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'h4000, 16'hfff8, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'hffff, 16'h0006, 4'd0, 3'b000));
    push_item(compose_item(arsel_pkg::OP_SELECT, 16'hc000, 16'h0005, 4'd0, 3'b000));
    in_valid <= 1'b0;
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p <= 1) begin
        send_idle = 10;
        recv_idle = 73;
      end else if (p <= 4) begin
        send_idle = 73;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: load_config(16'd0, 16'hffff, 16'd0, 16'd512, 5'd16);
        1: load_config(16'hffff, 16'd300, 16'd700, 16'd0, 5'd1);
        2: load_config(16'h8000, 16'($urandom), 16'($urandom), 16'($urandom), 5'd31);
        3: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 5'd0);
        4: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       5'($urandom_range(2, 15)));
        5: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       5'($urandom));
        default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 5'd16);
      endcase
      repeat (phase_items[p]) push_item(random_item(ledger.active()));
      in_valid <= 1'b0;
      settle();
    end

    $display("summary: %0d select beats (%0d with no allowed method), %0d weight updates",
             ledger.selects, ledger.empties, ledger.updates);
    $display("summary: %0d updates of inactive methods across %0d register settings",
             ledger.idle_updates, settings_loaded);
    if (ledger.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/arsel_pkg.sv
rtl/arsel_regs.sv
rtl/arsel_wmem.sv
rtl/arsel_engine.sv
rtl/adaptive_roulette_selector.sv
tb/testbench.sv
